[src/ctb_pkg.sv]
// Shared types and codes of the cascaded timer bank.
package ctb_pkg;

    localparam int BANKS       = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DIVIDE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_DIVIDE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_DIVIDE = 2'd2;

    localparam logic [7:0] BASE_DIVIDE_RST    = 8'd5;
    localparam logic [7:0] STAGE_DIVIDE_RST   = 8'd10;
    localparam logic [7:0] REFRESH_DIVIDE_RST = 8'd10;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  bank;
        logic [2:0]  slot;
        logic [15:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_value;
        logic        timer_zero;
        logic        refresh_flag;
    } t_out_item;

    // Control handed to the head cell for one position of the walk
    typedef struct packed {
        logic [1:0]       command;
        logic [1:0]       bank;
        logic [2:0]       slot;
        logic [15:0]      load_value;
        logic [1:0]       cur_bank;
        logic [2:0]       cur_slot;
        logic [BANKS-1:0] step_en;
        logic [7:0]       stage_divide;
    } t_step_ctl;

    typedef struct packed {
        logic cascade;
        logic read_hit;
    } t_step_res;

endpackage

[src/ctb_cell.sv]
// One timer cell of the ring: holds a count and takes its neighbor's while the ring turns.
module ctb_cell #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [COUNT_WIDTH-1:0] i_d,
    output logic [COUNT_WIDTH-1:0] o_q
);

    logic [COUNT_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[src/ctb_step.sv]
// Head of the ring: decrement, cascade reload, load and read match for the passing timer.
module ctb_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  ctb_pkg::t_step_ctl     i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_value,
    output logic [COUNT_WIDTH-1:0] o_value,
    output ctb_pkg::t_step_res     o_res
);

    logic                   stepping;
    logic                   match;
    logic [COUNT_WIDTH-1:0] dec_value;

    assign stepping = (i_ctl.command == ctb_pkg::CMD_TICK) && i_ctl.step_en[i_ctl.cur_bank];
    assign match    = (i_ctl.cur_bank == i_ctl.bank) && (i_ctl.cur_slot == i_ctl.slot);

    always_comb begin
        dec_value     = (i_value != '0) ? i_value - 1'b1 : i_value;
        o_value       = i_value;
        o_res.cascade = 1'b0;
        if (stepping) begin
            o_value = dec_value;
            // Cascade slot ran out: reload and step the next bank
            if ((i_ctl.cur_slot == 3'd0) && (i_ctl.cur_bank != 2'd3) && (dec_value == '0)) begin
                o_value       = COUNT_WIDTH'(i_ctl.stage_divide);
                o_res.cascade = 1'b1;
            end
        end
        if ((i_ctl.command == ctb_pkg::CMD_LOAD) && match) begin
            o_value = COUNT_WIDTH'(i_ctl.load_value);
        end
        o_res.read_hit = (i_ctl.command == ctb_pkg::CMD_READ) && match;
    end

endmodule

[src/cascaded_timer_bank.sv]
// Top level of the cascaded timer bank: dividers, ring of timer cells, walk control.
//
// Four banks of down-counting timers (1 ms, 10 ms, 100 ms, 1 s) held in a ring of
// cells, one cell per timer, bank 0 first. Input transactions carry a command
// (tick, load, read, clear refresh flag) with bank, slot and load value; each
// input transaction yields exactly one output transaction with the read value,
// the zero status of a read timer and the sticky refresh flag.
// A tick that does not fire the 1 ms step, and a clear, answer on the next cycle.
// A load, a read and a firing tick turn the ring once, passing each timer
// (MS_TIMERS + TEN_MS_TIMERS + HUNDRED_MS_TIMERS + SEC_TIMERS, 32 by default)
// through the head cell in turn; the result then waits until the output
// register is free and is presented there. The next input transaction is taken
// only once that result sits in the output register and is not stalled.
// The length of that walk through the ring sets the rate; one transaction is
// worked on at a time.
// Configuration writes (base, stage and refresh divide) are taken at any edge
// with i_cfg_we high and must only come while the block is idle.
// Reset clears all timers, loads the base divider with 5, clears the refresh
// count and flag, and sets the divide registers to 5, 10 and 10. A stalled
// result holds in the output register; the next input transaction is stalled
// until that result is taken.
module cascaded_timer_bank #(
    parameter int MS_TIMERS         = 8,
    parameter int TEN_MS_TIMERS     = 8,
    parameter int HUNDRED_MS_TIMERS = 8,
    parameter int SEC_TIMERS        = 8,
    parameter int COUNT_WIDTH       = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ctb_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ctb_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ctb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ctb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TOTAL = MS_TIMERS + TEN_MS_TIMERS + HUNDRED_MS_TIMERS + SEC_TIMERS;
    localparam int IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BANK_SIZE [ctb_pkg::BANKS] =
        '{MS_TIMERS, TEN_MS_TIMERS, HUNDRED_MS_TIMERS, SEC_TIMERS};

    // Configuration registers
    logic [7:0] r_base_divide, r_stage_divide, r_refresh_divide;

    // Dividers and flag
    logic [7:0] r_base_count, n_base_count;
    logic [7:0] r_refresh_count, n_refresh_count;
    logic       r_refresh, n_refresh;

    // Walk control
    logic                      r_busy, n_busy;
    logic                      r_pend, n_pend;
    logic [IW-1:0]             r_idx, n_idx;
    logic [1:0]                r_cur_bank, n_cur_bank;
    logic [2:0]                r_cur_slot, n_cur_slot;
    logic [ctb_pkg::BANKS-1:0] r_step_en, n_step_en;
    ctb_pkg::t_in_item         r_item, n_item;
    logic [15:0]               r_rd_value, n_rd_value;
    logic                      r_rd_zero, n_rd_zero;

    // Output register
    logic               r_out_valid, n_out_valid;
    ctb_pkg::t_out_item r_out, n_out;

    logic                   accept_in;
    logic                   out_free;
    logic                   fire;
    logic                   walk_last;
    logic [8:0]             refresh_next;
    logic [COUNT_WIDTH-1:0] ring_q [TOTAL];
    logic [COUNT_WIDTH-1:0] head_value;
    ctb_pkg::t_step_ctl     step_ctl;
    ctb_pkg::t_step_res     step_res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || r_pend || (r_out_valid && i_out_stall);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign walk_last  = (r_idx == IW'(TOTAL - 1));
    assign fire       = (r_base_count <= 8'd1);
    assign refresh_next = {1'b0, r_refresh_count} + 9'd1;

    // Ring of cells: each hands its count down, the head result re-enters at the top
    for (genvar g = 0; g < TOTAL; g++) begin : g_cell
        logic [COUNT_WIDTH-1:0] cell_d;
        if (g == TOTAL - 1) begin : g_top
            assign cell_d = head_value;
        end else begin : g_mid
            assign cell_d = ring_q[g+1];
        end
        ctb_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_busy),
            .i_d     (cell_d),
            .o_q     (ring_q[g])
        );
    end

    always_comb begin
        step_ctl.command      = r_item.command;
        step_ctl.bank         = r_item.bank;
        step_ctl.slot         = r_item.slot;
        step_ctl.load_value   = r_item.load_value;
        step_ctl.cur_bank     = r_cur_bank;
        step_ctl.cur_slot     = r_cur_slot;
        step_ctl.step_en      = r_step_en;
        step_ctl.stage_divide = r_stage_divide;
    end

    ctb_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_ctl   (step_ctl),
        .i_value (ring_q[0]),
        .o_value (head_value),
        .o_res   (step_res)
    );

    always_comb begin
        n_base_count    = r_base_count;
        n_refresh_count = r_refresh_count;
        n_refresh       = r_refresh;
        n_busy          = r_busy;
        n_pend          = r_pend;
        n_idx           = r_idx;
        n_cur_bank      = r_cur_bank;
        n_cur_slot      = r_cur_slot;
        n_step_en       = r_step_en;
        n_item          = r_item;
        n_rd_value      = r_rd_value;
        n_rd_zero       = r_rd_zero;
        n_out_valid     = r_out_valid;
        n_out           = r_out;

        // Drop a result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (accept_in) begin
            n_item     = i_in_data;
            n_idx      = '0;
            n_cur_bank = 2'd0;
            n_cur_slot = 3'd0;
            n_step_en  = '0;
            n_rd_value = '0;
            n_rd_zero  = 1'b0;
            case (i_in_data.command)
                ctb_pkg::CMD_TICK: begin
                    if (refresh_next >= {1'b0, r_refresh_divide}) begin
                        n_refresh_count = '0;
                        n_refresh       = 1'b1;
                    end else begin
                        n_refresh_count = refresh_next[7:0];
                    end
                    if (fire) begin
                        n_base_count = r_base_divide;
                        n_step_en    = ctb_pkg::BANKS'(1);
                        n_busy       = 1'b1;
                    end else begin
                        n_base_count = r_base_count - 8'd1;
                        n_out_valid  = 1'b1;
                        n_out        = '{read_value: '0, timer_zero: 1'b0,
                                         refresh_flag: n_refresh};
                    end
                end
                ctb_pkg::CMD_CLEAR: begin
                    n_refresh   = 1'b0;
                    n_out_valid = 1'b1;
                    n_out       = '{read_value: '0, timer_zero: 1'b0, refresh_flag: 1'b0};
                end
                default: begin
                    n_busy = 1'b1;
                end
            endcase
        end

        // Advance the walk one cell per cycle
        if (r_busy) begin
            if (step_res.cascade) begin
                n_step_en = r_step_en | (ctb_pkg::BANKS'(1) << 2'(r_cur_bank + 2'd1));
            end
            if (step_res.read_hit) begin
                n_rd_value = 16'(ring_q[0]);
                n_rd_zero  = (ring_q[0] == '0);
            end
            if (r_cur_slot == 3'(BANK_SIZE[r_cur_bank] - 1)) begin
                n_cur_slot = 3'd0;
                n_cur_bank = r_cur_bank + 2'd1;
            end else begin
                n_cur_slot = r_cur_slot + 3'd1;
            end
            n_idx = r_idx + 1'b1;
            if (walk_last) begin
                n_busy = 1'b0;
                n_pend = 1'b1;
            end
        end

        // Present the walk result when the output register is free
        if (r_pend && out_free) begin
            n_pend      = 1'b0;
            n_out_valid = 1'b1;
            n_out       = '{read_value: r_rd_value, timer_zero: r_rd_zero,
                            refresh_flag: r_refresh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_divide    <= ctb_pkg::BASE_DIVIDE_RST;
            r_stage_divide   <= ctb_pkg::STAGE_DIVIDE_RST;
            r_refresh_divide <= ctb_pkg::REFRESH_DIVIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ctb_pkg::REG_BASE_DIVIDE:    r_base_divide    <= i_cfg_data;
                ctb_pkg::REG_STAGE_DIVIDE:   r_stage_divide   <= i_cfg_data;
                ctb_pkg::REG_REFRESH_DIVIDE: r_refresh_divide <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_count    <= ctb_pkg::BASE_DIVIDE_RST;
            r_refresh_count <= '0;
            r_refresh       <= 1'b0;
            r_busy          <= 1'b0;
            r_pend          <= 1'b0;
            r_idx           <= '0;
            r_cur_bank      <= 2'd0;
            r_cur_slot      <= 3'd0;
            r_step_en       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_base_count    <= n_base_count;
            r_refresh_count <= n_refresh_count;
            r_refresh       <= n_refresh;
            r_busy          <= n_busy;
            r_pend          <= n_pend;
            r_idx           <= n_idx;
            r_cur_bank      <= n_cur_bank;
            r_cur_slot      <= n_cur_slot;
            r_step_en       <= n_step_en;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_rd_value <= n_rd_value;
        r_rd_zero  <= n_rd_zero;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A walk and a waiting walk result never overlap
    a_busy_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_pend))
        else $error("walk running while its result waits");

    // A bank only steps when the bank below it stepped
    a_cascade_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_step_en[3] || r_step_en[2]) && (!r_step_en[2] || r_step_en[1]) &&
        (!r_step_en[1] || r_step_en[0]))
        else $error("bank stepped without its lower bank");

    // The last cell of the walk hands over to a waiting result
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && walk_last) |=> (r_pend || o_out_valid))
        else $error("walk ended without a result");

    // A waiting result goes out as soon as the output register is free
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && out_free) |=> (o_out_valid && !r_pend))
        else $error("walk result not presented");

endmodule

[tb/sv/cascaded_timer_bank_tb.sv]
// Self-checking testbench for the cascaded timer bank: directed table, then randomized phases.
module cascaded_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Every bank holds eight timers, so no slot address ever falls outside a bank.
    localparam int SLOTS = 8;
    // A load, a read or a firing tick walks all 32 timers before its result is presented.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 115;

    // One row of the directed table: the transaction, and the result to expect
    // when it can be typed in directly. Untyped rows use the timer model instead.
    typedef struct packed {
        logic               typed;
        ctb_pkg::t_in_item  item;
        ctb_pkg::t_out_item want;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    ctb_pkg::t_in_item               i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    ctb_pkg::t_out_item              o_out_data;
    logic                            i_cfg_we = 1'b0;
    logic [ctb_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [ctb_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Timer model: counts, dividers and the sticky flag, plus the live register copies.
    logic [15:0] timer_cnt [0:3][0:SLOTS-1];
    logic [7:0]  base_cnt;
    logic [7:0]  refresh_cnt;
    logic        refresh_set;
    logic [7:0]  base_div;
    logic [7:0]  stage_div;
    logic [7:0]  refresh_div;

    ctb_pkg::t_out_item pending_responses [$];
    t_dir_row           directed_rows [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;

    cascaded_timer_bank DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Decrement every nonzero timer of one bank.
    function automatic void count_down_bank(input int b);
        for (int s = 0; s < SLOTS; s++) begin
            if (timer_cnt[b][s] != 16'd0) begin
                timer_cnt[b][s] = timer_cnt[b][s] - 16'd1;
            end
        end
    endfunction

    // Advance the timer model by one input transaction and return its result.
    function automatic ctb_pkg::t_out_item apply_command(input ctb_pkg::t_in_item it);
        ctb_pkg::t_out_item res;
        logic               carry;
        res = '0;
        case (it.command)
            ctb_pkg::CMD_TICK: begin
                // Refresh divider: compare one wider so a lowered divide cannot wrap.
                if ({1'b0, refresh_cnt} + 9'd1 >= {1'b0, refresh_div}) begin
                    refresh_cnt = 8'd0;
                    refresh_set = 1'b1;
                end else begin
                    refresh_cnt = refresh_cnt + 8'd1;
                end
                // Base divider: a count of 0 or 1 fires the 1 ms step and reloads.
                if (base_cnt > 8'd1) begin
                    base_cnt = base_cnt - 8'd1;
                end else begin
                    base_cnt = base_div;
                    count_down_bank(0);
                    // Ripple up while each cascade slot has run out; a stage divide of
                    // zero reloads zero, so the carry keeps going.
                    carry = 1'b1;
                    for (int b = 0; b < 3; b++) begin
                        if (carry && timer_cnt[b][0] == 16'd0) begin
                            timer_cnt[b][0] = {8'h00, stage_div};
                            count_down_bank(b + 1);
                        end else begin
                            carry = 1'b0;
                        end
                    end
                end
            end
            ctb_pkg::CMD_LOAD: begin
                timer_cnt[it.bank][it.slot] = it.load_value;
            end
            ctb_pkg::CMD_READ: begin
                res.read_value = timer_cnt[it.bank][it.slot];
                res.timer_zero = (timer_cnt[it.bank][it.slot] == 16'd0);
            end
            ctb_pkg::CMD_CLEAR: begin
                refresh_set = 1'b0;
            end
            default: ;
        endcase
        res.refresh_flag = refresh_set;
        return res;
    endfunction

    function automatic t_dir_row table_row(input logic typed, input logic [1:0] cmd,
                                           input logic [1:0] bank, input logic [2:0] slot,
                                           input logic [15:0] value, input logic [15:0] rv,
                                           input logic tz, input logic rf);
        t_dir_row r;
        r.typed = typed;
        r.item  = '{command: cmd, bank: bank, slot: slot, load_value: value};
        r.want  = '{read_value: rv, timer_zero: tz, refresh_flag: rf};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: MISMATCH result %0d %s: got %0h, expected %0h",
                 $time, results_seen, what, got, want);
    endtask

    // Offer one input transaction, optionally after a random gap, and hold it until taken.
    // Record the expected result at the edge that accepts it.
    task automatic send_item(input ctb_pkg::t_in_item it, input logic typed,
                             input ctb_pkg::t_out_item want);
        ctb_pkg::t_out_item predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_command(it);
        pending_responses.push_back(typed ? want : predicted);
    endtask

    // Drop valid, wait for every outstanding result, then let the walk settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three divide registers on back-to-back edges, then mirror them.
    task automatic set_dividers(input logic [7:0] base, input logic [7:0] stage,
                                input logic [7:0] refresh);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ctb_pkg::REG_BASE_DIVIDE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= ctb_pkg::REG_STAGE_DIVIDE;
        i_cfg_data  <= stage;
        @(posedge i_clk);
        i_cfg_index <= ctb_pkg::REG_REFRESH_DIVIDE;
        i_cfg_data  <= refresh;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        base_div    = base;
        stage_div   = stage;
        refresh_div = refresh;
    endtask

    // Result side: check each taken result against the oldest expectation, and
    // pick the stall for the next edge.
    always @(posedge i_clk) begin : result_check
        ctb_pkg::t_out_item got;
        ctb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got = o_out_data;
            results_seen++;
            if (pending_responses.size() == 0) begin
                report_mismatch("arrived with nothing pending", int'(got), 0);
            end else begin
                want = pending_responses.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", int'(got.read_value),
                                    int'(want.read_value));
                if (got.timer_zero !== want.timer_zero)
                    report_mismatch("timer_zero", int'(got.timer_zero),
                                    int'(want.timer_zero));
                if (got.refresh_flag !== want.refresh_flag)
                    report_mismatch("refresh_flag", int'(got.refresh_flag),
                                    int'(want.refresh_flag));
            end
        end
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cascaded_timer_bank_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        ctb_pkg::t_in_item item;
        int                roll;

        // Reset state of the model, matching the block after reset.
        for (int b = 0; b < 4; b++) begin
            for (int s = 0; s < SLOTS; s++) begin
                timer_cnt[b][s] = 16'd0;
            end
        end
        base_div    = ctb_pkg::BASE_DIVIDE_RST;
        stage_div   = ctb_pkg::STAGE_DIVIDE_RST;
        refresh_div = ctb_pkg::REFRESH_DIVIDE_RST;
        base_cnt    = ctb_pkg::BASE_DIVIDE_RST;
        refresh_cnt = 8'd0;
        refresh_set = 1'b0;

        // Directed table, run with the reset dividers (5, 10, 10).
        // After reset every timer reads zero with its zero status set.
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_READ, 2'd0, 3'd0, 16'h0000,
                                          16'h0000, 1'b1, 1'b0));
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_READ, 2'd3, 3'd7, 16'h0000,
                                          16'h0000, 1'b1, 1'b0));
        // Load the largest count and read it back whole.
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_LOAD, 2'd0, 3'd7, 16'hFFFF,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_READ, 2'd0, 3'd7, 16'h0000,
                                          16'hFFFF, 1'b0, 1'b0));
        // Seed timers in every bank that the first 1 ms step and its cascade will hit.
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_LOAD, 2'd0, 3'd1, 16'h0003,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_LOAD, 2'd1, 3'd5, 16'h0001,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_LOAD, 2'd3, 3'd7, 16'h0002,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_LOAD, 2'd2, 3'd4, 16'hAAAA,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_LOAD, 2'd3, 3'd6, 16'h5555,
                                          16'h0000, 1'b0, 1'b0));
        // Ten ticks: the fifth fires the 1 ms step with a full cascade, the tenth sets
        // the refresh flag.
        for (int i = 0; i < 10; i++) begin
            directed_rows.push_back(table_row(1'b0, ctb_pkg::CMD_TICK, 2'(i), 3'(i), 16'(i),
                                              16'h0000, 1'b0, 1'b0));
        end
        // Clearing the flag always leaves it low.
        directed_rows.push_back(table_row(1'b1, ctb_pkg::CMD_CLEAR, 2'd0, 3'd0, 16'h0000,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b0, ctb_pkg::CMD_READ, 2'd1, 3'd5, 16'h0000,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b0, ctb_pkg::CMD_READ, 2'd3, 3'd7, 16'h0000,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b0, ctb_pkg::CMD_READ, 2'd0, 3'd0, 16'h0000,
                                          16'h0000, 1'b0, 1'b0));
        directed_rows.push_back(table_row(1'b0, ctb_pkg::CMD_READ, 2'd2, 3'd4, 16'h0000,
                                          16'h0000, 1'b0, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // Randomized phases: each sets new dividers while idle and picks an idling mode.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: set_dividers(8'd1, 8'd1, 8'd1);
                // zero dividers: step on every tick, cascade on every step while cascade slots hold zero
                1: set_dividers(8'd0, 8'd0, 8'd0);
                2: set_dividers(8'd2, 8'd2, 8'd3);
                3: set_dividers(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                                8'($urandom_range(1, 8)));
                4: set_dividers(8'd3, 8'd255, 8'd255);
                // lower the refresh divide below the count left from the last phase
                5: set_dividers(8'd1, 8'd3, 8'd2);
                6: set_dividers(8'($urandom_range(1, 6)), 8'($urandom_range(1, 255)),
                                8'($urandom_range(1, 255)));
                default: set_dividers(8'd255, 8'd1, 8'd255);
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
            endcase

            repeat (ITEMS_PER_PHASE) begin
                // Tick-heavy mix with small loads so timers actually run out and cascade;
                // a quarter of loads span the full count range.
                roll = $urandom_range(99);
                if (roll < 50)      item.command = ctb_pkg::CMD_TICK;
                else if (roll < 70) item.command = ctb_pkg::CMD_LOAD;
                else if (roll < 94) item.command = ctb_pkg::CMD_READ;
                else                item.command = ctb_pkg::CMD_CLEAR;
                item.bank = 2'($urandom_range(3));
                item.slot = ($urandom_range(99) < 25) ? 3'd0 : 3'($urandom_range(SLOTS - 1));
                item.load_value = ($urandom_range(99) < 75) ? 16'($urandom_range(24))
                                                            : 16'($urandom_range(16'hFFFF));
                send_item(item, 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("cascaded_timer_bank_tb passed");
        end else begin
            $display("cascaded_timer_bank_tb failed");
        end
        $finish;
    end

endmodule
